@@ rtl/fedl_pkg.sv @@
`default_nettype none
package fedl_pkg;

    typedef logic signed [15:0] t_sample;

    localparam int unsigned GAIN_ONE = 32768;
    localparam logic signed [17:0] S16_MIN = -18'sd32768;
    localparam logic signed [17:0] S16_MAX = 18'sd32767;

    // configuration register indexes
    localparam logic CFG_FEEDBACK_GAIN = 1'b0;
    localparam logic CFG_DELAY_LENGTH  = 1'b1;

endpackage
`default_nettype wire

@@ rtl/feedback_echo_delay_line_unit.sv @@
`default_nettype none
// Feedback comb echo on signed 16-bit samples. Each sample x leaves as
// y = sat16(trunc(x*(1-g)) + trunc(d*g)), where d is the result written
// delay_length samples before and g is feedback_gain in Q1.15; y also goes
// back into the delay line, which holds LINE_DEPTH samples in one memory.
// The block takes one sample per clock cycle while the output is not
// stalled; a sample enters a stage register while its delay-line entry
// is read from the memory's single registered read port, and its result
// then moves on to the output register that drives m_axis_tvalid. A result
// written in the same cycle as a read of that entry is forwarded. A fill
// count marks the entries written since reset; entries beyond it read as
// zero, so no clearing pass follows reset. Configuration writes take effect
// with the next sample and are meant for an idle block.
module feedback_echo_delay_line_unit
    import fedl_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = 32768
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input samples
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] sample_in
    // echoed samples
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [15:0] sample_out
);

    localparam int unsigned AW = $clog2(LINE_DEPTH);
    localparam int unsigned LW = AW + 1;

    // configuration
    logic [15:0] r_gain;
    logic [15:0] r_delay;

    // write position and fill count
    logic [AW-1:0] r_wpos;
    logic [LW-1:0] r_fill;

    // stage register
    logic          r_s1_valid;
    t_sample       r_x;
    logic [AW-1:0] r_pos;
    t_sample       r_rd;
    logic          r_fwd;
    t_sample       r_fwd_y;
    logic          r_zero;

    // output register
    logic          r_out_valid;
    t_sample       r_out;

    t_sample       mem [LINE_DEPTH];

    logic          cfg_we;
    logic          in_accept;
    logic          s1_fire;
    logic [31:0]   len32;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] pos_ext;
    logic [LW-1:0] pos_inc;
    logic [AW-1:0] rd_pos;
    logic [AW-1:0] n_wpos;
    logic [16:0]   g_eff;
    logic [16:0]   g_inv;
    t_sample       d;
    logic signed [33:0] prod_x;
    logic signed [33:0] prod_d;
    logic signed [17:0] term_x;
    logic signed [17:0] term_d;
    logic signed [17:0] sum;
    t_sample       y;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 16'd0;
            r_delay <= 16'd32768;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_FEEDBACK_GAIN: r_gain  <= i_cfg_data;
                CFG_DELAY_LENGTH:  r_delay <= i_cfg_data;
                default:           r_gain  <= r_gain;
            endcase
        end
    end

    // the stage moves on whenever the output register is free or drained
    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // effective delay length and positions
    always_comb begin
        len32 = {16'd0, r_delay};
        if (len32 == 32'd0) begin
            len32 = 32'd1;
        end
        if (len32 > LINE_DEPTH) begin
            len32 = LINE_DEPTH;
        end
        len_eff = len32[LW-1:0];

        pos_ext = {1'b0, r_wpos};
        if (pos_ext >= len_eff) begin
            pos_ext = '0;
        end
        rd_pos  = pos_ext[AW-1:0];
        pos_inc = pos_ext + LW'(1);
        if (pos_inc >= len_eff) begin
            pos_inc = '0;
        end
        n_wpos = pos_inc[AW-1:0];
    end

    // mix and saturate
    always_comb begin
        g_eff = (r_gain > 16'd32768) ? 17'(GAIN_ONE) : {1'b0, r_gain};
        g_inv = 17'(GAIN_ONE) - g_eff;

        priority if (r_fwd) begin
            d = r_fwd_y;
        end else if (r_zero) begin
            d = '0;
        end else begin
            d = r_rd;
        end

        prod_x = r_x * $signed({1'b0, g_inv});
        prod_d = d * $signed({1'b0, g_eff});
        // truncate toward zero: bias negatives before the shift
        term_x = 18'((prod_x + (prod_x[33] ? 34'sd32767 : 34'sd0)) >>> 15);
        term_d = 18'((prod_d + (prod_d[33] ? 34'sd32767 : 34'sd0)) >>> 15);
        sum    = term_x + term_d;

        priority if (sum < S16_MIN) begin
            y = t_sample'(S16_MIN);
        end else if (sum > S16_MAX) begin
            y = t_sample'(S16_MAX);
        end else begin
            y = sum[15:0];
        end
    end

    // delay line memory
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            mem[r_pos] <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd <= mem[rd_pos];
        end
    end

    // stage register payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x     <= s_axis_tdata;
            r_pos   <= rd_pos;
            r_fwd_y <= y;
            // forward the result written at the same edge to the same entry
            r_fwd   <= s1_fire && (r_pos == rd_pos);
            r_zero  <= {1'b0, rd_pos} >= r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wpos     <= '0;
            r_fill     <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_wpos     <= n_wpos;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            // written entries always form a prefix of the line
            if (s1_fire && ({1'b0, r_pos} >= r_fill)) begin
                r_fill <= {1'b0, r_pos} + LW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= y;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
`default_nettype wire

@@ tb/echo_output_checker.sv @@
module echo_output_checker
    import fedl_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = 32768
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [15:0] i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_out_data,
    output int               o_fail_count,
    output int               o_echo_count
);
    timeunit 1ns;
    timeprecision 1ps;

    t_sample     echo_line [LINE_DEPTH];
    int unsigned head;
    logic [15:0] gain_reg;
    logic [15:0] length_reg;
    t_sample     echoes_due [$];
    int          mismatch_count;
    int          echoes_left;
    int          echoes_seen;

    assign o_fail_count = mismatch_count + echoes_left;
    assign o_echo_count = echoes_seen;

    // dry part plus fed-back part, each truncated toward zero, then clamped
    function automatic t_sample mix_echo(t_sample x, t_sample d, int g);
        longint dry;
        longint wet;
        longint y;
        dry = (longint'(x) * longint'(int'(GAIN_ONE) - g)) / longint'(GAIN_ONE);
        wet = (longint'(d) * longint'(g)) / longint'(GAIN_ONE);
        y = dry + wet;
        if (y < S16_MIN) y = S16_MIN;
        if (y > S16_MAX) y = S16_MAX;
        return t_sample'(y);
    endfunction

    always @(posedge i_clk) begin
        int          g;
        int unsigned len;
        t_sample     y;
        t_sample     want;
        t_sample     got;
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_DEPTH; i++) echo_line[i] = '0;
            head = 0;
            gain_reg = '0;
            length_reg = 16'd32768;
            echoes_due.delete();
            mismatch_count <= 0;
            echoes_left <= 0;
            echoes_seen <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FEEDBACK_GAIN: gain_reg = i_cfg_data;
                    CFG_DELAY_LENGTH:  length_reg = i_cfg_data;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                g = (int'(gain_reg) > int'(GAIN_ONE)) ? int'(GAIN_ONE) : int'(gain_reg);
                len = (length_reg == 16'd0) ? 1 : length_reg;
                if (len > LINE_DEPTH) len = LINE_DEPTH;
                // length lowered below the write position: restart at zero
                if (head >= len) head = 0;
                y = mix_echo(t_sample'(i_in_data), echo_line[head], g);
                echo_line[head] = y;
                head = head + 1;
                if (head >= len) head = 0;
                echoes_due.push_back(y);
            end
            if (i_out_valid && i_out_ready) begin
                echoes_seen <= echoes_seen + 1;
                got = t_sample'(i_out_data);
                if (echoes_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected echo %0d with nothing outstanding", got);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = echoes_due.pop_front();
                    if (want !== got) begin
                        if (mismatch_count < 10)
                            $display("echo mismatch: sample_out expected %0d, got %0d",
                                     want, got);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            echoes_left <= echoes_due.size();
        end
    end

endmodule

@@ tb/feedback_echo_delay_line_unit_tb.sv @@
module feedback_echo_delay_line_unit_tb
    import fedl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CALM_AFTER   = 1150;
    localparam int CHOKE_PHASE  = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_FEEDBACK_GAIN;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;

    int fail_count;
    int echo_count;
    int samples_sent = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    bit choke_req = 1'b0;
    bit choking = 1'b0;
    bit choke_done = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    feedback_echo_delay_line_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    echo_output_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_echo_count (echo_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_regs(logic [15:0] gain, logic [15:0] length);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FEEDBACK_GAIN;
        i_cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_DELAY_LENGTH;
        i_cfg_data  <= length;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(logic [15:0] x);
        if (!calm && !choking && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // drain: every sample sent has come back as an echo
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (echo_count < samples_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(32769, 65535));
            4:       return 16'd1;
            5:       return 16'd32767;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd32768;
            3:       return 16'hFFFF;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(2, 48));
        endcase
    endfunction

    // output side: random stalls, one long hold-off, none near the end
    initial begin
        @(posedge i_clk);
        forever begin
            if (calm) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else if (choke_req && !choke_done) begin
                m_axis_tready <= 1'b0;
                choking <= 1'b1;
                repeat (90) @(posedge i_clk);
                choking <= 1'b0;
                choke_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int target;
        int calm_at;
        int phase;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: gain zero passes samples straight through
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        settle();

        // gain above one, zero delay, write position past the new length
        write_regs(16'hFFFF, 16'd0);
        repeat (3) push_sample(16'h8000);
        settle();

        // exact unity gain, delay beyond the line
        write_regs(16'd32768, 16'hFFFF);
        push_sample(16'h7FFF);
        push_sample(16'h0001);
        settle();

        // half gain, short delay, full-scale inputs
        write_regs(16'd16384, 16'd2);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h7FFF);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        settle();

        target  = samples_sent + RANDOM_ITEMS;
        calm_at = samples_sent + CALM_AFTER;
        phase   = 0;
        while (samples_sent < target) begin
            write_regs(pick_gain(), pick_length());
            // hold off until the receiver stalls, then keep offering samples
            if (phase == CHOKE_PHASE) begin
                choke_req <= 1'b1;
                wait (choking);
            end
            n = $urandom_range(30, 150);
            repeat (n) begin
                if (samples_sent >= calm_at) calm <= 1'b1;
                push_sample(16'($urandom));
            end
            settle();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ feedback_echo_delay_line_unit.f @@
rtl/fedl_pkg.sv
rtl/feedback_echo_delay_line_unit.sv
tb/echo_output_checker.sv
tb/feedback_echo_delay_line_unit_tb.sv
